// File: rtl/smfh_pkg.sv
// Shared types and constants of the shared-medium frame hub.
package smfh_pkg;

  localparam int NumPortsDef    = 8;
  localparam int BufferDepthDef = 63;
  localparam int NumLinkRows    = 8;
  localparam int LinkW          = 64;
  localparam int PAddrW         = 6;

  localparam logic [7:0] StartByte = 8'hF0;

  typedef enum logic [1:0] {
    PhStart,
    PhLen,
    PhPayload
  } phase_e;

  typedef struct packed {
    logic [2:0] source_port;
    logic [7:0] data_byte;
    logic [7:0] random_threshold;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] sender_port;
    logic [7:0] dest_mask;
    logic       last;
  } out_item_t;

endpackage

// File: rtl/smfh_buf.sv
// Pending-byte store: one write port, one registered read port.
module smfh_buf import smfh_pkg::*; #(
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [1<<AddrW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: rtl/shared_medium_frame_hub.sv
// Top level of the shared-medium frame hub: lock, per-port framing, replay.
//
// Bytes enter on the input channel (valid/stall), each tagged with its source
// port and a random threshold. Frame bytes leave on the output channel, one
// transaction per byte, with the owning port, the destination mask sampled on
// the start byte and a last flag on the final byte caused by an input.
// Link quality rows are written over the APB port, 64 bits at 8*row.
//
// Sequence: an input transaction is taken in S_IDLE and evaluated in the
// next cycle in S_EVAL; a byte that is stored, or dropped on a full buffer or
// an unused port, returns to S_IDLE from there, and a parsed byte (forwarded
// or a bad start byte) passes on through S_FLUSH, which hands any held result
// over. When a port wins the lock with bytes stored, the replay walks its
// buffer one byte per cycle while the receiver does not stall, then flushes.
// Stored bytes sit in a synchronous memory, one row of slots per port; its
// registered read is covered by issuing each read ahead of the byte's use.
// Results pass through a holding stage and an output register, so the next
// input is taken while the last result still waits for the receiver.
// A stalled receiver holds the output register; the replay then pauses.
// Reset frees the medium, returns all ports to waiting for a start byte,
// empties all buffers and clears the link rows. Buffer contents are not
// cleared; the fill count alone tells which slots are live.
module shared_medium_frame_hub import smfh_pkg::*; #(
  parameter int NumPorts    = NumPortsDef,
  parameter int BufferDepth = BufferDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [LinkW-1:0]  pwdata,
  output logic [LinkW-1:0]  prdata,
  output logic              pready
);

  localparam int PortW = $clog2(NumPorts);
  localparam int CntW  = $clog2(BufferDepth + 1);
  localparam int RamAw = PortW + CntW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_REPLAY,
    S_FLUSH
  } state_e;

  state_e           state_q;
  in_item_t         item_q;
  logic             lock_q;
  logic [CntW-1:0]  idx_q;
  logic             h_valid_q;
  out_item_t        h_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [LinkW-1:0] link_q  [NumLinkRows];
  phase_e           phase_q [NumPorts];
  logic [7:0]       pcnt_q  [NumPorts];
  logic [7:0]       flen_q  [NumPorts];
  logic [7:0]       mask_q  [NumPorts];
  logic [CntW-1:0]  pend_q  [NumPorts];

  logic [PortW-1:0] pp;
  logic             port_ok;
  phase_e           cur_phase;
  logic [7:0]       cur_cnt, cur_len, cur_mask;
  logic [CntW-1:0]  cur_pend;
  logic [7:0]       rd_data, pbyte, sampled;
  logic             out_free, can_step, out_load;
  phase_e           n_phase;
  logic [7:0]       n_cnt, n_len, n_mask, res_mask;
  logic             emit, bad, fend;
  logic [8:0]       nxt, target;
  logic             wr_en;
  logic [CntW-1:0]  rd_slot;

  assign pp        = item_q.source_port[PortW-1:0];
  assign port_ok   = int'(item_q.source_port) < NumPorts;
  assign cur_phase = phase_q[pp];
  assign cur_cnt   = pcnt_q[pp];
  assign cur_len   = flen_q[pp];
  assign cur_mask  = mask_q[pp];
  assign cur_pend  = pend_q[pp];

  assign out_free = !out_valid_q || !out_stall_i;
  assign can_step = !h_valid_q || out_free;

  // Load the output register this cycle from the holding stage.
  assign out_load = (state_q == S_REPLAY && can_step && emit && h_valid_q) ||
                    (state_q == S_FLUSH && h_valid_q && out_free);

  // Replay reads stored bytes until the slot index reaches the fill count,
  // then the new byte itself.
  assign pbyte = (state_q == S_REPLAY && idx_q != cur_pend) ? rd_data : item_q.data_byte;

  always_comb begin
    sampled = '0;
    for (int d = 0; d < 8; d++) begin
      if (d < NumPorts && link_q[item_q.source_port][8*d +: 8] > item_q.random_threshold) begin
        sampled[d] = 1'b1;
      end
    end
  end

  // Frame parser for one byte of the current port.
  always_comb begin
    n_phase  = cur_phase;
    n_cnt    = cur_cnt;
    n_len    = cur_len;
    n_mask   = cur_mask;
    res_mask = cur_mask;
    emit     = 1'b0;
    bad      = 1'b0;
    fend     = 1'b0;
    nxt      = {1'b0, cur_cnt} + 9'd1;
    target   = (cur_len == 8'd0) ? 9'd256 : {1'b0, cur_len};
    case (cur_phase)
      PhLen: begin
        n_len   = pbyte;
        emit    = 1'b1;
        n_phase = PhPayload;
      end
      PhPayload: begin
        emit = 1'b1;
        if (nxt == target) begin
          n_phase = PhStart;
          n_cnt   = '0;
          n_len   = '0;
          n_mask  = '0;
          fend    = 1'b1;
        end else begin
          n_cnt = nxt[7:0];
        end
      end
      default: begin
        if (pbyte == StartByte) begin
          n_mask   = sampled;
          res_mask = sampled;
          emit     = 1'b1;
          n_phase  = PhLen;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
  end

  assign wr_en = state_q == S_EVAL && port_ok && cur_phase == PhStart && lock_q &&
                 int'(cur_pend) < BufferDepth;

  always_comb begin
    rd_slot = idx_q;
    if (state_q == S_EVAL) begin
      rd_slot = '0;
    end else if (state_q == S_REPLAY && can_step && idx_q != cur_pend) begin
      rd_slot = idx_q + 1'b1;
    end
  end

  smfh_buf #(
    .AddrW(RamAw)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i({pp, cur_pend}),
    .wr_data_i(item_q.data_byte),
    .rd_addr_i({pp, rd_slot}),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lock_q      <= 1'b0;
      idx_q       <= '0;
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumLinkRows; i++) begin
        link_q[i] <= '0;
      end
      for (int i = 0; i < NumPorts; i++) begin
        phase_q[i] <= PhStart;
        pcnt_q[i]  <= '0;
        flen_q[i]  <= '0;
        mask_q[i]  <= '0;
        pend_q[i]  <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        link_q[paddr[PAddrW-1:3]] <= pwdata;
      end
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!port_ok) begin
            state_q <= S_IDLE;
          end else if (cur_phase == PhStart && lock_q) begin
            // medium busy: store the byte, drop it when the row is full
            if (int'(cur_pend) < BufferDepth) begin
              pend_q[pp] <= cur_pend + 1'b1;
            end
            state_q <= S_IDLE;
          end else if (cur_pend == '0) begin
            phase_q[pp] <= n_phase;
            pcnt_q[pp]  <= n_cnt;
            flen_q[pp]  <= n_len;
            mask_q[pp]  <= n_mask;
            if (emit) begin
              h_q       <= '{out_byte: pbyte, sender_port: item_q.source_port,
                             dest_mask: res_mask, last: 1'b0};
              h_valid_q <= 1'b1;
            end
            if (bad || fend) begin
              lock_q <= 1'b0;
            end else if (cur_phase == PhStart) begin
              lock_q <= 1'b1;
            end
            state_q <= S_FLUSH;
          end else begin
            lock_q  <= 1'b1;
            idx_q   <= '0;
            state_q <= S_REPLAY;
          end
        end
        S_REPLAY: begin
          if (can_step) begin
            phase_q[pp] <= n_phase;
            pcnt_q[pp]  <= n_cnt;
            flen_q[pp]  <= n_len;
            mask_q[pp]  <= n_mask;
            if (emit) begin
              if (h_valid_q) begin
                out_q       <= h_q;
                out_valid_q <= 1'b1;
              end
              h_q       <= '{out_byte: pbyte, sender_port: item_q.source_port,
                             dest_mask: res_mask, last: 1'b0};
              h_valid_q <= 1'b1;
            end
            if (idx_q == cur_pend) begin
              pend_q[pp] <= '0;
              if (n_phase == PhStart) begin
                lock_q <= 1'b0;
              end
              state_q <= S_FLUSH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (!h_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q       <= '{out_byte: h_q.out_byte, sender_port: h_q.sender_port,
                             dest_mask: h_q.dest_mask, last: 1'b1};
            out_valid_q <= 1'b1;
            h_valid_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign prdata      = link_q[paddr[PAddrW-1:3]];
  assign pready      = 1'b1;

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !h_valid_q)
    else $error("held result left behind at end of item");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_EVAL)
    else $error("accepted transaction not evaluated");

  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REPLAY |-> idx_q <= cur_pend && lock_q)
    else $error("replay index beyond fill count or lock lost");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && port_ok |-> int'(cur_pend) <= BufferDepth)
    else $error("buffer fill count exceeds depth");

endmodule
